>>> hdl/xtce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xtce_pkg
// Shared types, constants and tag-character helpers for the tag extractor.
// ----------------------------------------------------------------------------
package xtce_pkg;

    localparam int unsigned MAX_TAG_CHARS = 8;
    localparam int unsigned CMD_DEPTH_DEF = 4;

    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    localparam logic REG_TAG_TEXT   = 1'b0;
    localparam logic REG_TAG_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        KIND_CONTENT   = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_NOT_FOUND = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_CONTENT = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    // one word of work for the back end
    typedef struct packed {
        kind_t      kind;
        logic [3:0] held;
        logic       with_byte;
        logic [7:0] data;
    } cmd_t;

    function automatic logic [7:0] name_char(input logic [63:0] text, input logic [3:0] i);
        logic [2:0] sel;
        begin
            sel = i[2:0];
            return text[{sel, 3'b000} +: 8];
        end
    endfunction

    // bit 8 set: past the end of "<name>"
    function automatic logic [8:0] open_char(input logic [63:0] text, input logic [3:0] n,
                                             input logic [3:0] i);
        logic [4:0] ix;
        logic [4:0] nx;
        begin
            ix = {1'b0, i};
            nx = {1'b0, n};
            if (ix == 5'd0)
                return {1'b0, CHAR_LT};
            else if (ix <= nx)
                return {1'b0, name_char(text, i - 4'd1)};
            else if (ix == nx + 5'd1)
                return {1'b0, CHAR_GT};
            else
                return 9'h100;
        end
    endfunction

    // bit 8 set: past the end of "</name>"
    function automatic logic [8:0] close_char(input logic [63:0] text, input logic [3:0] n,
                                              input logic [3:0] i);
        logic [4:0] ix;
        logic [4:0] nx;
        begin
            ix = {1'b0, i};
            nx = {1'b0, n};
            if (ix == 5'd0)
                return {1'b0, CHAR_LT};
            else if (ix == 5'd1)
                return {1'b0, CHAR_SLASH};
            else if (ix <= nx + 5'd1)
                return {1'b0, name_char(text, i - 4'd2)};
            else if (ix == nx + 5'd2)
                return {1'b0, CHAR_GT};
            else
                return 9'h100;
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/xml_tag_content_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xml_tag_content_extractor
// Streams a document byte by byte, finds the first <name> tag and returns the
// bytes up to the matching </name>, followed by a found or not-found status.
// ----------------------------------------------------------------------------
// One document byte is taken every cycle while full is low. Each byte yields
// zero, one or several result words; a byte that breaks a partial closing tag
// releases the held prefix plus itself, or holds itself as a new prefix if it
// is '<', up to the name length plus three words (eleven at most). The back
// end drains one word per cycle through its output register while results
// are popped; the command queue (CMD_DEPTH entries) lets the matcher keep
// taking bytes meanwhile, and full rises only when it fills. The user writes
// the tag registers through cfg_write/cfg_index/cfg_data only while the block
// is idle; the block does not enforce this. A write drops any partial tag match.
module xml_tag_content_extractor #(
    parameter int unsigned CMD_DEPTH = xtce_pkg::CMD_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output      logic        full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        document_end,
    output      logic        empty,
    input  wire logic        pop,
    output      logic [7:0]  out_byte,
    output      logic [1:0]  result_kind,
    output      logic        run_last,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);
    import xtce_pkg::*;

    logic [63:0] tag_text_reg;
    logic [3:0]  tag_length_reg;
    logic [3:0]  name_len;
    logic        accept;
    logic        cmd_push;
    cmd_t        cmd_in;
    cmd_t        cmd_out;
    logic        q_empty;
    logic        q_pop;

    localparam logic [3:0] MAX_LEN = 4'(MAX_TAG_CHARS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_text_reg   <= 64'd0;
            tag_length_reg <= 4'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TAG_TEXT:   tag_text_reg   <= cfg_data;
                REG_TAG_LENGTH: tag_length_reg <= cfg_data[3:0];
                default:        tag_text_reg   <= tag_text_reg;
            endcase
        end
    end

    always_comb
    begin
        if (tag_length_reg == 4'd0)
            name_len = 4'd1;
        else if (tag_length_reg > MAX_LEN)
            name_len = MAX_LEN;
        else
            name_len = tag_length_reg;
    end

    assign accept = push && !full;

    xtce_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .document_end (document_end),
        .cfg_write    (cfg_write),
        .tag_text     (tag_text_reg),
        .name_len     (name_len),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    xtce_cmd_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (cmd_out),
        .empty   (q_empty)
    );

    xtce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (cmd_out),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .tag_text    (tag_text_reg),
        .name_len    (name_len),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .result_kind (result_kind),
        .run_last    (run_last)
    );

endmodule
`default_nettype wire

>>> hdl/xtce_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xtce_front
// Tag matcher: tracks the opening and closing tag and issues one command word
// per input byte that yields results.
// ----------------------------------------------------------------------------
module xtce_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 document_end,
    input  wire logic                 cfg_write,
    input  wire logic [63:0]          tag_text,
    input  wire logic [3:0]           name_len,
    output      logic                 cmd_push,
    output      xtce_pkg::cmd_t       cmd
);
    import xtce_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] open_cnt_reg, open_cnt_next;
    logic [3:0] close_cnt_reg, close_cnt_next;

    logic [8:0] oc;
    logic [8:0] cc;
    logic [3:0] cnt_inc;
    logic       found;

    always_comb
    begin
        oc             = open_char(tag_text, name_len, open_cnt_reg);
        cc             = close_char(tag_text, name_len, close_cnt_reg);
        cnt_inc        = 4'd0;
        found          = 1'b0;
        phase_next     = phase_reg;
        open_cnt_next  = open_cnt_reg;
        close_cnt_next = close_cnt_reg;
        cmd.kind       = KIND_CONTENT;
        cmd.held       = 4'd0;
        cmd.with_byte  = 1'b0;
        cmd.data       = data_byte;

        case (phase_reg)
            PH_CONTENT:
            begin
                if (!cc[8] && cc[7:0] == data_byte)
                begin
                    cnt_inc = close_cnt_reg + 4'd1;
                    if (cnt_inc == name_len + 4'd3)
                    begin
                        found          = 1'b1;
                        phase_next     = PH_DONE;
                        close_cnt_next = 4'd0;
                    end
                    else
                    begin
                        close_cnt_next = cnt_inc;
                    end
                end
                else
                begin
                    cmd.held = close_cnt_reg;
                    if (data_byte == CHAR_LT)
                    begin
                        close_cnt_next = 4'd1;
                    end
                    else
                    begin
                        cmd.with_byte  = 1'b1;
                        close_cnt_next = 4'd0;
                    end
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
                if (!oc[8] && oc[7:0] == data_byte)
                begin
                    cnt_inc = open_cnt_reg + 4'd1;
                    if (cnt_inc == name_len + 4'd2)
                    begin
                        phase_next     = PH_CONTENT;
                        open_cnt_next  = 4'd0;
                        close_cnt_next = 4'd0;
                    end
                    else
                    begin
                        open_cnt_next = cnt_inc;
                    end
                end
                else
                begin
                    open_cnt_next = (data_byte == CHAR_LT) ? 4'd1 : 4'd0;
                end
            end
        endcase

        if (found)
        begin
            cmd.kind = KIND_FOUND;
        end
        else if (document_end && phase_next != PH_DONE)
        begin
            cmd.kind = KIND_NOT_FOUND;
        end

        if (document_end)
        begin
            phase_next     = PH_SEARCH;
            open_cnt_next  = 4'd0;
            close_cnt_next = 4'd0;
        end

        cmd_push = accept && (cmd.kind != KIND_CONTENT || cmd.held != 4'd0 || cmd.with_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            open_cnt_reg  <= 4'd0;
            close_cnt_reg <= 4'd0;
        end
        else if (cfg_write)
        begin
            open_cnt_reg  <= 4'd0;
            close_cnt_reg <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            open_cnt_reg  <= open_cnt_next;
            close_cnt_reg <= close_cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/xtce_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xtce_cmd_queue
// Small first-in first-out queue of command words between front and back.
// ----------------------------------------------------------------------------
module xtce_cmd_queue #(
    parameter int unsigned DEPTH = xtce_pkg::CMD_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire xtce_pkg::cmd_t wr_data,
    output      logic           full,
    input  wire logic           rd_en,
    output      xtce_pkg::cmd_t rd_data,
    output      logic           empty
);
    import xtce_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

>>> hdl/xtce_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xtce_back
// Expands command words into result words, one per cycle while the consumer
// pops, through a single output register.
// ----------------------------------------------------------------------------
module xtce_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire xtce_pkg::cmd_t       q_data,
    input  wire logic                 q_empty,
    output      logic                 q_pop,
    input  wire logic [63:0]          tag_text,
    input  wire logic [3:0]           name_len,
    output      logic                 empty,
    input  wire logic                 pop,
    output      logic [7:0]           out_byte,
    output      logic [1:0]           result_kind,
    output      logic                 run_last
);
    import xtce_pkg::*;

    logic       busy_reg, busy_next;
    cmd_t       cmd_reg, cmd_next;
    logic [3:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    kind_t      kind_reg, kind_next;
    logic       last_reg, last_next;

    cmd_t       cur;
    logic [3:0] cur_idx;
    logic       have;
    logic       load;
    logic [8:0] cc;

    always_comb
    begin
        cur            = busy_reg ? cmd_reg : q_data;
        cur_idx        = busy_reg ? idx_reg : 4'd0;
        have           = busy_reg || !q_empty;
        load           = have && (!out_valid_reg || pop);
        q_pop          = load && !busy_reg;
        cc             = close_char(tag_text, name_len, cur_idx);

        busy_next      = busy_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !pop;
        out_byte_next  = out_byte_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            kind_next      = cur.kind;
            if (cur.kind != KIND_CONTENT)
            begin
                out_byte_next = 8'd0;
                last_next     = 1'b1;
            end
            else if (cur_idx < cur.held)
            begin
                out_byte_next = cc[7:0];
                last_next     = !cur.with_byte && (cur_idx == cur.held - 4'd1);
            end
            else
            begin
                out_byte_next = cur.data;
                last_next     = 1'b1;
            end
            busy_next = !last_next;
            cmd_next  = cur;
            idx_next  = cur_idx + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_byte_reg <= out_byte_next;
        kind_reg     <= kind_next;
        last_reg     <= last_next;
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign result_kind = kind_reg;
    assign run_last    = last_reg;

endmodule
`default_nettype wire
